### hdl/sacc_pkg.sv
// ----------------------------------------------------------------------------
// sacc_pkg: shared types and constants
// Geometry defaults, policy and status codes, and the front-to-back queue
// entry for the set-associative cache controller.
// ----------------------------------------------------------------------------
package sacc_pkg;

  localparam int unsigned NumSetsDef    = 64;
  localparam int unsigned NumWaysDef    = 4;
  localparam int unsigned BlockWordsDef = 16;

  typedef enum logic [1:0] {
    POL_ROTATE = 2'd0,
    POL_LRU    = 2'd1,
    POL_PLRU   = 2'd2,
    POL_LRU_B  = 2'd3
  } policy_e;

  typedef enum logic [1:0] {
    ST_HIT       = 2'd0,
    ST_MISS_FILL = 2'd1,
    ST_MISS_CLN  = 2'd2,
    ST_MISS_DRT  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    BK_CLR,
    BK_IDLE,
    BK_LOOK,
    BK_OUT
  } bk_state_e;

  // decoded request handed from front to back
  typedef struct packed {
    logic        wr;
    logic [31:0] addr;
    logic [7:0]  wdata;
  } req_t;

  // result word
  typedef struct packed {
    logic [31:0] wb_addr;
    logic        wb_valid;
    logic        cap_miss;
    logic [7:0]  rdata;
    logic [1:0]  status;
  } rsp_t;

endpackage

### hdl/sacc_front.sv
// ----------------------------------------------------------------------------
// sacc_front: request intake
// Accepts stream words and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module sacc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_tvalid_i,
  output logic          s_tready_o,
  input  sacc_pkg::req_t s_req_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output sacc_pkg::req_t q_req_o
);
  import sacc_pkg::*;

  req_t       mem_q [2];
  logic       wp_q, rp_q, wp_d, rp_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push, pop;

  assign s_tready_o = (cnt_q != 2'd2);
  assign push       = s_tvalid_i && s_tready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_pop_i && q_valid_o;
  assign q_req_o    = mem_q[rp_q];

  always_comb begin
    wp_d  = wp_q ^ push;
    rp_d  = rp_q ^ pop;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= s_req_i;
    end
  end

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 2'd2) else $error("queue count overflow");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd2 |-> !push) else $error("push into full queue");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> cnt_q != 2'd0) else $error("pop from empty queue");
`endif

endmodule

### hdl/sacc_back.sv
// ----------------------------------------------------------------------------
// sacc_back: lookup, replacement and update
// Reads a set's tags and state, resolves hit or victim, writes back the set
// and presents the result word in an output register.
// ----------------------------------------------------------------------------
module sacc_back #(
  parameter int unsigned NUM_SETS    = sacc_pkg::NumSetsDef,
  parameter int unsigned NUM_WAYS    = sacc_pkg::NumWaysDef,
  parameter int unsigned BLOCK_WORDS = sacc_pkg::BlockWordsDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic [1:0]     policy_i,
  input  logic           q_valid_i,
  output logic           q_pop_o,
  input  sacc_pkg::req_t q_req_i,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output sacc_pkg::rsp_t m_rsp_o
);
  import sacc_pkg::*;

  localparam int unsigned OB  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS + 1) - 1 : 0;
  localparam int unsigned IB  = (NUM_SETS > 1) ? $clog2(NUM_SETS + 1) - 1 : 0;
  localparam int unsigned TW  = 32 - OB - IB;
  localparam int unsigned SW  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int unsigned WW  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned OW  = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
  localparam int unsigned CW  = $clog2(NUM_WAYS + 1);
  localparam int unsigned NL  = NUM_SETS * NUM_WAYS;
  localparam int unsigned TCW = $clog2(NL + 1);
  localparam int unsigned TB  = (NUM_WAYS > 1) ? NUM_WAYS - 1 : 1;
  localparam int unsigned DEP = NUM_WAYS - 1;

  typedef logic [NUM_WAYS-1:0][TW-1:0]          tags_t;
  typedef logic [NUM_WAYS-1:0][WW-1:0]          ranks_t;
  typedef logic [NUM_WAYS-1:0]                  wbits_t;
  typedef logic [NUM_WAYS-1:0][BLOCK_WORDS-1:0] lmask_t;
  typedef logic [NUM_WAYS-1:0][7:0]             bytes_t;

  // per-set line and replacement state
  typedef struct packed {
    wbits_t        vld;
    wbits_t        drt;
    ranks_t        rank;
    logic [TB-1:0] tree;
    logic [WW-1:0] rot;
    logic [CW-1:0] fill;
  } set_st_t;

  // set-wide stores, all read together when a word is popped;
  // mask_mem marks the bytes written since a line was filled, the rest read 0
  tags_t          tag_mem  [NUM_SETS];
  set_st_t        sst_mem  [NUM_SETS];
  lmask_t         mask_mem [NUM_SETS];
  bytes_t         byte_mem [NUM_SETS*BLOCK_WORDS];
  logic [TCW-1:0] total_q, total_d;
  logic [SW-1:0]  clr_q;

  bk_state_e  st_q, st_d;
  req_t       req_q;
  tags_t      tags_r;
  set_st_t    sst_r, sst_n, sst_rst;
  lmask_t     mask_r, mask_n;
  bytes_t     bytes_r;
  logic [7:0] byte_r;
  rsp_t       rsp_q, rsp_d;

  logic [SW-1:0] set_a, set_r;
  logic [TW-1:0] tag_a;
  logic [OW-1:0] off_a, off_in;
  wbits_t        vld_s, drt_s;
  ranks_t        rank_s, rank_n;
  logic [TB-1:0] tree_s, tree_n;
  logic [WW-1:0] rot_s, rot_n;
  logic          hit;
  logic [WW-1:0] hway, vway, way, pos, node_pos;
  logic          upd;

  assign set_a  = SW'((q_req_i.addr >> OB) & 32'(NUM_SETS - 1));
  assign off_in = OW'(q_req_i.addr & 32'(BLOCK_WORDS - 1));
  assign set_r  = SW'((req_q.addr >> OB) & 32'(NUM_SETS - 1));
  assign tag_a  = TW'(req_q.addr >> (OB + IB));
  assign off_a  = OW'(req_q.addr & 32'(BLOCK_WORDS - 1));

  assign vld_s  = sst_r.vld;
  assign drt_s  = sst_r.drt;
  assign rank_s = sst_r.rank;
  assign tree_s = sst_r.tree;
  assign rot_s  = sst_r.rot;

  function automatic logic [WW-1:0] way_at(ranks_t r, logic [WW-1:0] p);
    logic [WW-1:0] res;
    res = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (r[i] == p) res = WW'(i);
    end
    return res;
  endfunction

  always_comb begin
    int unsigned node;
    hit  = 1'b0;
    hway = '0;
    for (int i = NUM_WAYS - 1; i >= 0; i--) begin
      if (vld_s[i] && tags_r[i] == tag_a) begin
        hit  = 1'b1;
        hway = WW'(i);
      end
    end
    node = 0;
    for (int d = 0; d < 5; d++) begin
      if (node < DEP) node = 2 * node + 32'(tree_s[node]) + 1;
    end
    node_pos = WW'(node - DEP);
    case (policy_e'(policy_i))
      POL_ROTATE: vway = way_at(rank_s, rot_s);
      POL_PLRU:   vway = way_at(rank_s, node_pos);
      default: begin
        vway = way_at(rank_s, WW'(NUM_WAYS - 1));
        for (int p = NUM_WAYS - 2; p >= 0; p--) begin
          if (!vld_s[way_at(rank_s, WW'(p))]) vway = way_at(rank_s, WW'(p));
        end
      end
    endcase
    way = hit ? hway : vway;
    pos = rank_s[way];
    rank_n = rank_s;
    tree_n = tree_s;
    node = 32'(pos) + DEP;
    for (int d = 0; d < 4; d++) begin
      if (node > 0) begin
        tree_n[(node - 1) / 2] = node[0];
        node = (node - 1) / 2;
      end
    end
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (rank_s[i] < pos) rank_n[i] = rank_s[i] + 1'b1;
    end
    rank_n[way] = '0;
    rot_n = (rot_s == WW'(NUM_WAYS - 1)) ? '0 : rot_s + 1'b1;
    upd = (st_q == BK_LOOK);
  end

  // updated set state, write mask and read byte
  always_comb begin
    sst_n = sst_r;
    sst_n.vld[way] = 1'b1;
    sst_n.drt[way] = hit ? (drt_s[way] | req_q.wr) : req_q.wr;
    if (!hit && !vld_s[way]) sst_n.fill = sst_r.fill + 1'b1;
    case (policy_e'(policy_i))
      POL_ROTATE: if (!hit) sst_n.rot = rot_n;
      POL_PLRU:   sst_n.tree = tree_n;
      default:    sst_n.rank = rank_n;
    endcase
    mask_n = mask_r;
    if (!hit) mask_n[way] = '0;
    if (req_q.wr) mask_n[way][off_a] = 1'b1;
    byte_r = mask_r[hway][off_a] ? bytes_r[hway] : 8'd0;
  end

  always_comb begin
    sst_rst = '0;
    for (int i = 0; i < NUM_WAYS; i++) sst_rst.rank[i] = WW'(i);
  end

  // result word
  always_comb begin
    logic full;
    rsp_d = '0;
    total_d = total_q;
    full = (sst_r.fill == CW'(NUM_WAYS));
    if (hit) begin
      rsp_d.status = ST_HIT;
      rsp_d.rdata  = req_q.wr ? 8'd0 : byte_r;
    end else begin
      rsp_d.status = ST_MISS_FILL;
      if (vld_s[way]) begin
        if (full) rsp_d.status = drt_s[way] ? ST_MISS_DRT : ST_MISS_CLN;
        if (drt_s[way]) begin
          rsp_d.wb_valid = 1'b1;
          rsp_d.wb_addr  = ((32'(tags_r[way]) << IB) | 32'(set_r)) << OB;
        end
      end else begin
        total_d = total_q + 1'b1;
      end
      rsp_d.cap_miss = (rsp_d.status == ST_MISS_CLN || rsp_d.status == ST_MISS_DRT)
                       && (NUM_SETS == 1 || total_d == TCW'(NL));
    end
  end

  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    case (st_q)
      BK_CLR:  if (clr_q == SW'(NUM_SETS - 1)) st_d = BK_IDLE;
      BK_IDLE: if (q_valid_i) begin
        q_pop_o = 1'b1;
        st_d    = BK_LOOK;
      end
      BK_LOOK: st_d = BK_OUT;
      // next lookup starts as the result word leaves
      BK_OUT: if (m_ready_i) begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          st_d    = BK_LOOK;
        end else begin
          st_d    = BK_IDLE;
        end
      end
      default: st_d = BK_IDLE;
    endcase
  end

  assign m_valid_o = (st_q == BK_OUT);
  assign m_rsp_o   = rsp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= BK_CLR;
      clr_q   <= '0;
      total_q <= '0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_CLR) clr_q <= clr_q + 1'b1;
      if (upd) total_q <= total_d;
    end
  end

  // memories: read on pop, write on update; set state cleared after reset
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      req_q   <= q_req_i;
      tags_r  <= tag_mem[set_a];
      sst_r   <= sst_mem[set_a];
      mask_r  <= mask_mem[set_a];
      bytes_r <= byte_mem[{set_a, off_in}];
    end
    if (st_q == BK_CLR) sst_mem[clr_q] <= sst_rst;
    if (upd) begin
      rsp_q            <= rsp_d;
      sst_mem[set_r]   <= sst_n;
      mask_mem[set_r]  <= mask_n;
      if (!hit) tag_mem[set_r][way] <= tag_a;
      if (req_q.wr) byte_mem[{set_r, off_a}][way] <= req_q.wdata;
    end
  end

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && !m_ready_i |=> m_valid_o) else $error("result dropped");
  a_one_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |=> st_q == BK_LOOK) else $error("pop without lookup");
  a_wb_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_o && rsp_q.wb_valid |-> rsp_q.status != ST_HIT) else $error("wb on hit");
`endif

endmodule

### hdl/set_assoc_cache_controller_top.sv
// Path: an accepted input word is queued, popped into the back end's set read,
// then its result word is registered; a stalled result holds the back end and
// the two-word queue. Each word takes a set read then a set update; the next
// word is popped as the result word leaves. Reset sets the policy register
// to true LRU; the back end then clears each set's state, queue still fills.
// ----------------------------------------------------------------------------
// set_assoc_cache_controller_top: write-back set-associative cache
// Front queue plus back-end lookup and replacement.
// ----------------------------------------------------------------------------
module set_assoc_cache_controller_top #(
  parameter int unsigned NUM_SETS    = sacc_pkg::NumSetsDef,
  parameter int unsigned NUM_WAYS    = sacc_pkg::NumWaysDef,
  parameter int unsigned BLOCK_WORDS = sacc_pkg::BlockWordsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // address[31:0], write_data[39:32]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // status, read_data, capacity_miss,
                                      // writeback_valid, writeback_address
);
  import sacc_pkg::*;

  logic [1:0] policy_q;
  req_t       s_req, q_req;
  logic       q_valid, q_pop;
  rsp_t       rsp;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) policy_q <= POL_LRU;
    else if (cfg_valid_i) policy_q <= cfg_data_i;
  end

  assign s_req.wr    = s_axis_tuser;
  assign s_req.addr  = s_axis_tdata[31:0];
  assign s_req.wdata = s_axis_tdata[39:32];

  sacc_front u_front (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_o(s_axis_tready), .s_req_i(s_req),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_req_o(q_req)
  );

  sacc_back #(.NUM_SETS(NUM_SETS), .NUM_WAYS(NUM_WAYS), .BLOCK_WORDS(BLOCK_WORDS))
  u_back (
    .clk_i, .rst_ni, .policy_i(policy_q),
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_req_i(q_req),
    .m_valid_o(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_rsp_o(rsp)
  );

  assign m_axis_tdata = {4'd0, rsp.wb_addr, rsp.wb_valid, rsp.cap_miss,
                         rsp.rdata, rsp.status};

endmodule

### verif/cache_scoreboard.sv
// ----------------------------------------------------------------------------
// cache_scoreboard: cache controller result checker
// Watches the policy, request and result channels, keeps its own model of
// the tag, data and replacement stores, and compares every result word
// field by field with the oldest predicted one.
// ----------------------------------------------------------------------------
module cache_scoreboard (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_data_i,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  logic [39:0] req_data_i,
  input  logic        req_user_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  logic [47:0] rsp_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          rsp_count_o
);
  import sacc_pkg::*;

  localparam int Sets  = NumSetsDef;
  localparam int Ways  = NumWaysDef;
  localparam int Words = BlockWordsDef;
  localparam int Lines = Sets * Ways;
  localparam int OffBits = $clog2(Words);
  localparam int SetBits = $clog2(Sets);

  typedef struct {
    status_e     status;
    logic [7:0]  rdata;
    logic        cap_miss;
    logic        wb_valid;
    logic [31:0] wb_addr;
  } cache_rsp_t;

  policy_e     policy;
  logic [21:0] tag_mem   [Lines];
  logic        valid_mem [Lines];
  logic        dirty_mem [Lines];
  logic [7:0]  byte_mem  [Lines*Words];
  logic [1:0]  rank_mem  [Lines];
  logic [2:0]  tree_mem  [Sets];
  logic [1:0]  rot_mem   [Sets];
  int          fill_cnt  [Sets];
  int          total_valid;
  cache_rsp_t  expected_q[$];

  assign pending_o = expected_q.size();

  function automatic int way_at(int base, int pos);
    for (int w = 0; w < Ways; w++) if (rank_mem[base+w] == pos) return w;
    return 0;
  endfunction

  function automatic int choose_victim(int set);
    int base, node, pos, w;
    base = set * Ways;
    if (policy == POL_ROTATE) begin
      pos = rot_mem[set];
      rot_mem[set] = rot_mem[set] + 2'd1;
      return way_at(base, pos);
    end
    if (policy == POL_PLRU) begin
      node = 0;
      while (node < Ways - 1) node = 2*node + tree_mem[set][node] + 1;
      return way_at(base, node - (Ways - 1));
    end
    for (pos = 0; pos < Ways - 1; pos++) begin
      w = way_at(base, pos);
      if (!valid_mem[base+w]) return w;
    end
    return way_at(base, Ways - 1);
  endfunction

  function automatic void touch_way(int set, int way);
    int base, r, node, parent;
    base = set * Ways;
    r = rank_mem[base+way];
    if (policy == POL_ROTATE) return;
    if (policy == POL_PLRU) begin
      node = r + Ways - 1;
      while (node > 0) begin
        parent = (node - 1) / 2;
        tree_mem[set][parent] = node[0];
        node = parent;
      end
      return;
    end
    for (int w = 0; w < Ways; w++) if (rank_mem[base+w] < r) rank_mem[base+w]++;
    rank_mem[base+way] = 0;
  endfunction

  function automatic cache_rsp_t access_line(logic wr, logic [31:0] addr, logic [7:0] wd);
    cache_rsp_t r;
    int off, set, base, way, line;
    logic [21:0] tag;
    logic hit;
    off  = addr[OffBits-1:0];
    set  = addr[OffBits +: SetBits];
    tag  = addr[31:OffBits+SetBits];
    base = set * Ways;
    r = '{ST_HIT, 8'd0, 1'b0, 1'b0, 32'd0};
    hit = 1'b0;
    way = 0;
    for (int w = 0; w < Ways; w++)
      if (!hit && valid_mem[base+w] && tag_mem[base+w] == tag) begin
        hit = 1'b1;
        way = w;
      end
    if (hit) begin
      line = base + way;
      if (wr) begin
        byte_mem[line*Words+off] = wd;
        dirty_mem[line] = 1'b1;
      end else begin
        r.rdata = byte_mem[line*Words+off];
      end
    end else begin
      way = choose_victim(set);
      line = base + way;
      r.status = ST_MISS_FILL;
      if (valid_mem[line]) begin
        // a valid victim only counts as an eviction once the set is full
        if (fill_cnt[set] == Ways) r.status = dirty_mem[line] ? ST_MISS_DRT : ST_MISS_CLN;
        if (dirty_mem[line]) begin
          r.wb_valid = 1'b1;
          r.wb_addr  = {tag_mem[line], set[SetBits-1:0], {OffBits{1'b0}}};
        end
      end else begin
        fill_cnt[set]++;
        total_valid++;
      end
      tag_mem[line]   = tag;
      valid_mem[line] = 1'b1;
      dirty_mem[line] = wr;
      for (int i = 0; i < Words; i++) byte_mem[line*Words+i] = 8'd0;
      if (wr) byte_mem[line*Words+off] = wd;
      r.cap_miss = (r.status == ST_MISS_CLN || r.status == ST_MISS_DRT) &&
                   (Sets == 1 || total_valid == Lines);
    end
    touch_way(set, way);
    return r;
  endfunction

  task automatic report(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (errors_o < 10)
      $display("mismatch on word %0d, %s: expected %h, got %h", rsp_count_o, field,
               exp_v, act_v);
    errors_o++;
  endtask

  initial begin
    errors_o = 0;
    rsp_count_o = 0;
    policy = POL_LRU;
    total_valid = 0;
    for (int i = 0; i < Lines; i++) begin
      valid_mem[i] = 1'b0;
      dirty_mem[i] = 1'b0;
      rank_mem[i]  = 2'(i % Ways);
    end
    for (int s = 0; s < Sets; s++) begin
      tree_mem[s] = '0;
      rot_mem[s]  = '0;
      fill_cnt[s] = 0;
    end
  end

  always @(posedge clk_i) begin
    cache_rsp_t e;
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_i) policy = policy_e'(cfg_data_i);
      if (req_valid_i && req_ready_i)
        expected_q.push_back(access_line(req_user_i, req_data_i[31:0], req_data_i[39:32]));
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected word", 32'd0, rsp_data_i[31:0]);
        end else begin
          e = expected_q.pop_front();
          if (rsp_data_i[1:0] != e.status)   report("status", e.status, rsp_data_i[1:0]);
          if (rsp_data_i[9:2] != e.rdata)    report("read_data", e.rdata, rsp_data_i[9:2]);
          if (rsp_data_i[10] != e.cap_miss)  report("capacity_miss", e.cap_miss, rsp_data_i[10]);
          if (rsp_data_i[11] != e.wb_valid)  report("writeback_valid", e.wb_valid, rsp_data_i[11]);
          if (rsp_data_i[43:12] != e.wb_addr)
            report("writeback_address", e.wb_addr, rsp_data_i[43:12]);
          if (rsp_data_i[47:44] != 4'd0)     report("pad bits", 0, rsp_data_i[47:44]);
        end
        rsp_count_o++;
      end
    end
  end

endmodule

### verif/set_assoc_cache_controller_top_test.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_controller_top_test: cache controller testbench
// Directed hits, misses and evictions, a fill of the whole cache, then
// random traffic over a small tag pool under every replacement policy and
// several sender and receiver idling patterns; the scoreboard checks words.
// ----------------------------------------------------------------------------
module set_assoc_cache_controller_top_test;
  import sacc_pkg::*;

  localparam int CycleLimit = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;    // address[31:0], write_data[39:32]
  logic        s_axis_tuser = 1'b0;  // req_type
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;         // status, read_data, capacity_miss,
                                     // writeback_valid, writeback_address
  int          errors, pending, words_seen;
  int          cycles = 0;
  int          idle_mode = 0;        // 0 none, 1 sender, 2 receiver, 3 both
  int          sent = 0;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  set_assoc_cache_controller_top uut (.*);

  cache_scoreboard scoreboard (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .req_valid_i(s_axis_tvalid), .req_ready_i(s_axis_tready),
    .req_data_i(s_axis_tdata), .req_user_i(s_axis_tuser),
    .rsp_valid_i(m_axis_tvalid), .rsp_ready_i(m_axis_tready), .rsp_data_i(m_axis_tdata),
    .errors_o(errors), .pending_o(pending), .rsp_count_o(words_seen)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycles, pending);
      $display("FAIL set_assoc_cache_controller_top");
      $finish;
    end
  end

  // receiver stalls 64 percent of the time alone, 14 percent when both sides idle
  always @(negedge clk_i)
    m_axis_tready <= (idle_mode == 2) ? ($urandom_range(0, 99) >= 64) :
                     (idle_mode == 3) ? ($urandom_range(0, 99) >= 14) : 1'b1;

  task automatic send_req(logic wr, logic [31:0] addr, logic [7:0] wd);
    int idle_pct;
    idle_pct = (idle_mode == 3) ? 14 : 64;
    if (idle_mode == 1 || idle_mode == 3)
      while ($urandom_range(0, 99) < idle_pct) begin
        s_axis_tvalid = 1'b0;
        @(negedge clk_i);
      end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = wr;
    s_axis_tdata  = {wd, addr};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent++;
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_policy(policy_e p);
    drain();
    cfg_valid_i = 1'b1;
    cfg_data_i  = p;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // mostly a small pool of tags in a few sets so lines hit and get evicted
  task automatic random_req();
    logic [21:0] tag;
    logic [5:0]  set;
    logic [31:0] addr;
    case ($urandom_range(0, 5))
      0, 1, 2: tag = 22'($urandom_range(0, 5));
      3:       tag = 22'h3FFFFF - 22'($urandom_range(0, 1));
      4:       tag = 22'($urandom_range(8, 11));
      default: tag = 22'($urandom);
    endcase
    set = ($urandom_range(0, 2) == 0) ? 6'($urandom_range(0, 63)) : 6'($urandom_range(0, 3));
    addr = {tag, set, 4'($urandom)};
    if ($urandom_range(0, 9) == 0) addr = $urandom;
    send_req(1'($urandom_range(0, 1)), addr, 8'($urandom));
  endtask

  initial begin
    policy_e pols[5];
    pols = '{POL_ROTATE, POL_PLRU, POL_LRU_B, POL_LRU, POL_PLRU};
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: extreme addresses, hit after write, then overflow one set
    send_req(1'b1, 32'h0000_0000, 8'hFF);
    send_req(1'b0, 32'h0000_0000, 8'h00);
    send_req(1'b0, 32'h0000_0001, 8'hAA);
    send_req(1'b1, 32'hFFFF_FFFF, 8'h00);
    send_req(1'b0, 32'hFFFF_FFFF, 8'h55);
    send_req(1'b1, 32'hFFFF_FFFF, 8'hA5);
    send_req(1'b0, 32'hFFFF_FFFF, 8'h00);
    for (int t = 1; t <= 5; t++) send_req(t[0], {22'(t), 6'd0, 4'(t)}, 8'(t * 17));
    send_req(1'b0, {22'd0, 6'd0, 4'd0}, 8'h00);
    send_req(1'b0, {22'd5, 6'd0, 4'd5}, 8'h00);
    for (int t = 6; t <= 9; t++) send_req(1'b1, {22'(t), 6'd0, 4'd15}, 8'h80 | 8'(t));
    send_req(1'b0, {22'h2AAAAA, 6'h2A, 4'hA}, 8'h00);
    send_req(1'b1, {22'h155555, 6'h15, 4'h5}, 8'h5A);

    // fill every line so later evictions count as capacity misses
    write_policy(POL_LRU);
    for (int i = 0; i < 256; i++)
      send_req(1'($urandom_range(0, 1)), {22'(8 + i / 64), 6'(i % 64), 4'($urandom)},
               8'($urandom));

    for (int p = 0; p < 5; p++) begin
      write_policy(pols[p]);
      idle_mode = (p + 1) % 4;
      for (int i = 0; i < 70; i++) random_req();
      idle_mode = 0;
      for (int i = 0; i < 15; i++) random_req();
    end

    drain();
    $display("%0d requests sent, %0d result words checked, policies 0 to 3 exercised",
             sent, words_seen);
    $display("idle patterns: none, sender, receiver and both; cache filled completely");
    if (errors == 0 && pending == 0) begin
      $display("PASS set_assoc_cache_controller_top");
    end else begin
      $display("%0d mismatches, %0d words missing", errors, pending);
      $display("FAIL set_assoc_cache_controller_top");
    end
    $finish;
  end

endmodule
